// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants of the text console writer: transaction
// structs, command and status codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// Default geometry of the character buffer
	localparam int TCW_COLUMNS = 80;
	localparam int TCW_ROWS    = 25;

	// Cell contents and special character bytes
	localparam logic [15:0] BLANK_CELL = 16'h0F20;
	localparam logic [7:0]  NL_CODE    = 8'd10;
	localparam logic [7:0]  CR_CODE    = 8'd13;

	// Command codes
	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_PUT   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	// Result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_LINE  = 2'd1;
	localparam logic [1:0] STATUS_NO_STRING = 2'd2;

	// Input transaction
	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  start_line;
		logic [7:0]  char_code;
		logic [7:0]  attribute;
		logic [10:0] cell_address;
	} item_t;

	// Output transaction
	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  next_line;
		logic [10:0] cursor_position;
		logic [15:0] cell_data;
	} result_t;

	// Controller to datapath commands
	typedef struct packed {
		logic       load_item;
		logic       begin_line;
		logic       clear_active;
		logic       col_zero;
		logic       row_inc;
		logic       write_char;
		logic       rd_cell;
		logic       sweep_prime;
		logic       sweep_step;
		logic       sweep_clear;
		logic       load_out;
		logic [1:0] out_status;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] command;
		logic       line_ok;
		logic       string_active;
		logic       is_nl;
		logic       is_cr;
		logic       wrap;
		logic       row_last;
		logic       sweep_last;
	} dp_status_t;

endpackage

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a ROWS x COLUMNS buffer of 16-bit cells.
// Each transaction is accepted, executed (twice with a lazy wrap) and its
// result loaded; no new transaction is taken until the result register is
// loaded, which waits until the previous result has been taken.
// A scroll primes the read-ahead, then moves one buffer cell per cycle
// through the single read and single write port of the cell memory.
// Reset: a clearing pass zeroes the buffer; no input transaction is taken
// until it ends.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
	parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  tcw_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output tcw_pkg::result_t result
);

	tcw_pkg::dp_cmd_t    dp_cmd;
	tcw_pkg::dp_status_t dp_status;

	// Controller
	tcw_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.st           (dp_status),
		.cmd          (dp_cmd)
	);

	// Datapath
	tcw_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cmd    (dp_cmd),
		.st     (dp_status)
	);

`ifndef SYNTH
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("input taken while a transaction is in progress");

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready |-> !dp_cmd.sweep_step)
		else $error("input ready during a buffer sweep");

	a_write_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.write_char |-> !dp_cmd.sweep_step)
		else $error("character write collides with a sweep write");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load_out |-> (!result_valid || result_ready))
		else $error("result overwritten before it was taken");
`endif

endmodule

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller of the text console writer: sequences the clearing pass, command
// execution, buffer scroll and result hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  tcw_pkg::dp_status_t st,
	output tcw_pkg::dp_cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_EXEC   = 6'b000100,
		S_PRIME  = 6'b001000,
		S_SCROLL = 6'b010000,
		S_FIN    = 6'b100000
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] status_q, status_d;
	logic       resume_q, resume_d;
	logic       result_valid_q;

	// Decode state and command into datapath controls
	always_comb begin
		cmd            = '0;
		cmd.out_status = status_q;
		state_d        = state_q;
		status_d       = status_q;
		resume_d       = resume_q;
		item_ready     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep_step  = 1'b1;
				cmd.sweep_clear = 1'b1;
				if (st.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				status_d = tcw_pkg::STATUS_OK;
				state_d  = S_FIN;
				case (st.command)
					tcw_pkg::CMD_BEGIN: begin
						if (st.line_ok) begin
							cmd.begin_line = 1'b1;
						end else begin
							cmd.clear_active = 1'b1;
							status_d         = tcw_pkg::STATUS_BAD_LINE;
						end
					end
					tcw_pkg::CMD_PUT: begin
						if (!st.string_active) begin
							status_d = tcw_pkg::STATUS_NO_STRING;
						end else if (st.is_nl) begin
							cmd.col_zero = 1'b1;
							if (st.row_last) begin
								resume_d = 1'b0;
								state_d  = S_PRIME;
							end else begin
								cmd.row_inc = 1'b1;
							end
						end else if (st.is_cr) begin
							cmd.col_zero = 1'b1;
						end else if (st.wrap) begin
							// wrap first, then come back to write the character
							cmd.col_zero = 1'b1;
							if (st.row_last) begin
								resume_d = 1'b1;
								state_d  = S_PRIME;
							end else begin
								cmd.row_inc = 1'b1;
								state_d     = S_EXEC;
							end
						end else begin
							cmd.write_char = 1'b1;
						end
					end
					tcw_pkg::CMD_READ: begin
						cmd.rd_cell = 1'b1;
					end
					default: begin
					end
				endcase
			end
			S_PRIME: begin
				cmd.sweep_prime = 1'b1;
				state_d         = S_SCROLL;
			end
			S_SCROLL: begin
				cmd.sweep_step = 1'b1;
				if (st.sweep_last) begin
					state_d = resume_q ? S_EXEC : S_FIN;
				end
			end
			S_FIN: begin
				if (!result_valid_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			status_q <= tcw_pkg::STATUS_OK;
			resume_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			resume_q <= resume_d;
		end
	end

	// Track the output register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;

endmodule

// ----- rtl/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath of the text console writer: cell buffer memory, cursor registers,
// sweep pointer for clearing and scrolling, and the result register.
// ----------------------------------------------------------------------------
module tcw_datapath #(
	parameter int COLUMNS = tcw_pkg::TCW_COLUMNS,
	parameter int ROWS    = tcw_pkg::TCW_ROWS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcw_pkg::item_t      item,
	output tcw_pkg::result_t    result,
	input  tcw_pkg::dp_cmd_t    cmd,
	output tcw_pkg::dp_status_t st
);

	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int AW         = $clog2(CELL_COUNT);
	localparam int CW         = (AW + 1 > 11) ? AW + 1 : 11;
	localparam int RW         = $clog2(ROWS);
	localparam int CLW        = $clog2(COLUMNS + 1);
	localparam int NLW        = (RW + 1 > 5) ? RW + 1 : 5;

	tcw_pkg::item_t   item_q;
	tcw_pkg::result_t result_q;
	logic [RW-1:0]    row_q;
	logic [CLW-1:0]   col_q;
	logic             active_q;
	logic [10:0]      cursor_q;
	logic [AW-1:0]    ptr_q;
	logic [15:0]      rd_data_q;
	logic [15:0]      cells_q [CELL_COUNT];

	logic [AW-1:0]    idx;
	logic [CW-1:0]    idx_w;
	logic [CW-1:0]    addr_w;
	logic             addr_ok;
	logic [NLW-1:0]   next_line_w;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [15:0]      wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;

	// Cell index of the cursor and the read address check
	assign idx         = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign idx_w       = CW'(idx);
	assign addr_w      = CW'(item_q.cell_address);
	assign addr_ok     = addr_w < CW'(CELL_COUNT);
	assign next_line_w = NLW'(row_q) + NLW'(1);

	// Report decode status to the controller
	always_comb begin
		st.command       = item_q.command;
		st.line_ok       = item_q.start_line < 8'(ROWS);
		st.string_active = active_q;
		st.is_nl         = item_q.char_code == tcw_pkg::NL_CODE;
		st.is_cr         = item_q.char_code == tcw_pkg::CR_CODE;
		st.wrap          = col_q >= CLW'(COLUMNS);
		st.row_last      = row_q == RW'(ROWS - 1);
		st.sweep_last    = ptr_q == AW'(CELL_COUNT - 1);
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= item;
		end
	end

	// Advance line, column, string and cursor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			active_q <= 1'b0;
			cursor_q <= '0;
		end else begin
			if (cmd.begin_line) begin
				row_q <= item_q.start_line[RW-1:0];
			end else if (cmd.row_inc) begin
				row_q <= row_q + RW'(1);
			end
			if (cmd.begin_line || cmd.col_zero) begin
				col_q <= '0;
			end else if (cmd.write_char) begin
				col_q <= col_q + CLW'(1);
			end
			if (cmd.begin_line) begin
				active_q <= 1'b1;
			end else if (cmd.clear_active) begin
				active_q <= 1'b0;
			end
			if (cmd.write_char) begin
				cursor_q <= idx_w[10:0];
			end
		end
	end

	// Step the sweep pointer through the buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.sweep_prime) begin
			ptr_q <= '0;
		end else if (cmd.sweep_step) begin
			ptr_q <= st.sweep_last ? '0 : ptr_q + AW'(1);
		end
	end

	// Select the write port: sweep writes or a character cell
	always_comb begin
		wr_en   = cmd.write_char || cmd.sweep_step;
		wr_addr = idx;
		wr_data = {item_q.attribute, item_q.char_code};
		if (cmd.sweep_step) begin
			wr_addr = ptr_q;
			if (cmd.sweep_clear) begin
				wr_data = '0;
			end else if (ptr_q < AW'(CELL_COUNT - COLUMNS)) begin
				wr_data = rd_data_q;
			end else begin
				wr_data = tcw_pkg::BLANK_CELL;
			end
		end
	end

	// Select the read port: display read or scroll read-ahead one row down
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = addr_w[AW-1:0];
		if (cmd.rd_cell) begin
			rd_en = addr_ok;
		end else if (cmd.sweep_prime) begin
			rd_en   = 1'b1;
			rd_addr = AW'(COLUMNS);
		end else if (cmd.sweep_step && !cmd.sweep_clear) begin
			rd_en   = ptr_q < AW'(CELL_COUNT - COLUMNS - 1);
			rd_addr = ptr_q + AW'(COLUMNS + 1);
		end
	end

	// Cell buffer memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cells_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= cells_q[rd_addr];
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			result_q.status          <= cmd.out_status;
			result_q.next_line       <= next_line_w[4:0];
			result_q.cursor_position <= cursor_q;
			result_q.cell_data       <= (item_q.command == tcw_pkg::CMD_READ && addr_ok)
				? rd_data_q : 16'h0000;
		end
	end

	assign result = result_q;

endmodule

// ----- tb/text_console_writer_test.sv -----
// ----------------------------------------------------------------------------
// text_console_writer_test
// Self-checking bench for the text console writer. A scoreboard object keeps
// its own copy of the character buffer, cursor and string state, predicts
// one result per accepted command and checks every result field by field.
// Stimulus is a short directed opening followed by random strings, reads and
// noise, with bursty input, a patterned output stall and one long hold-off.
// ----------------------------------------------------------------------------
module text_console_writer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	localparam int COLUMNS         = TCW_COLUMNS;
	localparam int ROWS            = TCW_ROWS;
	localparam int CELL_COUNT      = COLUMNS * ROWS;
	localparam int CLK_HALF        = 2;
	localparam int RESET_CYCLES    = 8;
	localparam int ITEM_TARGET     = 750;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int HOLD_OFF_AFTER  = 150;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int DRAIN_CYCLES    = 8;

	// Command value the block does not decode
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// ------------------------------------------------------------------
	// Console scoreboard: shadow buffer plus queue of expected results
	// ------------------------------------------------------------------
	class console_scoreboard;
		logic [15:0]  cells [CELL_COUNT];
		int unsigned  row;
		int unsigned  column;
		bit           string_open;
		logic [10:0]  cursor;
		result_t      expected_q [$];
		int unsigned  mismatches;
		int unsigned  checked;
		int unsigned  cmd_count [4];
		int unsigned  bad_lines;
		int unsigned  orphan_puts;
		int unsigned  scrolls;
		int unsigned  wraps;

		function new();
			foreach (cells[i])
				cells[i] = '0;
			row         = 0;
			column      = 0;
			string_open = 1'b0;
			cursor      = '0;
			mismatches  = 0;
			checked     = 0;
			bad_lines   = 0;
			orphan_puts = 0;
			scrolls     = 0;
			wraps       = 0;
			foreach (cmd_count[i])
				cmd_count[i] = 0;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// Move down one row; below the bottom row, scroll the buffer up
		function void next_row();
			if (row == ROWS - 1) begin
				for (int i = 0; i < CELL_COUNT - COLUMNS; i++)
					cells[i] = cells[i + COLUMNS];
				for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
					cells[i] = BLANK_CELL;
				scrolls++;
			end else begin
				row++;
			end
		endfunction

		// Apply one accepted command and queue the result it must produce
		function void note_item(item_t it);
			result_t     want;
			int unsigned idx;
			want        = '0;
			want.status = STATUS_OK;
			cmd_count[it.command]++;
			case (it.command)
				CMD_BEGIN: begin
					if (it.start_line >= ROWS) begin
						want.status = STATUS_BAD_LINE;
						string_open = 1'b0;
						bad_lines++;
					end else begin
						row         = it.start_line;
						column      = 0;
						string_open = 1'b1;
					end
				end
				CMD_PUT: begin
					if (!string_open) begin
						want.status = STATUS_NO_STRING;
						orphan_puts++;
					end else if (it.char_code == NL_CODE) begin
						column = 0;
						next_row();
					end else if (it.char_code == CR_CODE) begin
						column = 0;
					end else begin
						// wrap lazily only when a printable byte needs the cell
						if (column >= COLUMNS) begin
							column = 0;
							next_row();
							wraps++;
						end
						idx        = row * COLUMNS + column;
						cursor     = 11'(idx);
						cells[idx] = {it.attribute, it.char_code};
						column++;
					end
				end
				CMD_READ: begin
					if (it.cell_address < CELL_COUNT)
						want.cell_data = cells[it.cell_address];
				end
				default: begin
				end
			endcase
			want.next_line       = 5'(row + 1);
			want.cursor_position = cursor;
			expected_q.push_back(want);
		endfunction

		function void compare_field(string field, int unsigned want, int unsigned got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h",
					$time, field, want, got);
				mismatches++;
			end
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(result_t got);
			result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual 'h%0h",
					$time, got);
				mismatches++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			compare_field("status", want.status, got.status);
			compare_field("next_line", want.next_line, got.next_line);
			compare_field("cursor_position", want.cursor_position, got.cursor_position);
			compare_field("cell_data", want.cell_data, got.cell_data);
		endfunction
	endclass

	// ------------------------------------------------------------------
	// Signals and block instance
	// ------------------------------------------------------------------
	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	console_scoreboard sb;
	int unsigned       items_sent    = 0;
	int unsigned       burst_left    = 0;
	int unsigned       idle_cycles   = 0;
	bit                hold_off_done = 1'b0;

	text_console_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Monitor: feed both handshakes to the scoreboard, track idle cycles
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (item_valid && item_ready)
			sb.note_item(item);
		if (result_valid && result_ready)
			sb.check_result(result);
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
			WATCHDOG_LIMIT, sb.pending());
		$display("== FAIL ==");
		$finish;
	end

	// ------------------------------------------------------------------
	// Receiver: stall on a rotating mask, hold off once for a long stretch
	// ------------------------------------------------------------------
	initial begin : receiver
		int unsigned stretch;
		logic [7:0]  stall_mask;
		result_ready = 1'b0;
		forever begin
			stretch    = $urandom_range(200, 10);
			stall_mask = 8'($urandom);
			if ($urandom_range(3) == 0)
				stall_mask = 8'hFF;
			for (int i = 0; i < stretch; i++) begin
				@(posedge clk);
				result_ready <= stall_mask[i % 8];
			end
			// hold off while the sender keeps offering, so the block backs up
			if (!hold_off_done && sb.checked >= HOLD_OFF_AFTER) begin
				hold_off_done = 1'b1;
				@(posedge clk);
				result_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------
	function automatic item_t pack_item(logic [1:0] cmd, int unsigned line,
			int unsigned ch, int unsigned attr, int unsigned addr);
		item_t it;
		it.command      = cmd;
		it.start_line   = 8'(line);
		it.char_code    = 8'(ch);
		it.attribute    = 8'(attr);
		it.cell_address = 11'(addr);
		return it;
	endfunction

	// Offer one transaction in bursts with random gaps; return once accepted
	task automatic offer_item(input item_t it);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(12, 1);
			if (gap != 0) begin
				item_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(40, 1);
		end
		burst_left--;
		item_valid <= 1'b1;
		item       <= it;
		do
			@(posedge clk);
		while (!item_ready);
		if (it.command != CMD_UNUSED)
			items_sent++;
	endtask

	initial begin : stimulus
		int unsigned pick;
		int unsigned line;
		int unsigned len;
		int unsigned roll;
		int unsigned ch;
		int unsigned addr;
		bit          wide;

		sb         = new();
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: rejects, edge bytes, control codes, scroll, reads
		offer_item(pack_item(CMD_READ, 0, 0, 0, 0));
		offer_item(pack_item(CMD_PUT, 0, 8'h41, 8'h1F, 0));
		offer_item(pack_item(CMD_BEGIN, ROWS, 0, 0, 0));
		offer_item(pack_item(CMD_BEGIN, 255, 0, 0, 0));
		offer_item(pack_item(CMD_BEGIN, 0, 0, 0, 0));
		offer_item(pack_item(CMD_PUT, 0, 8'h41, 8'h1F, 0));
		offer_item(pack_item(CMD_PUT, 0, 8'h00, 8'hFF, 0));
		offer_item(pack_item(CMD_PUT, 0, 8'hFF, 8'h00, 0));
		offer_item(pack_item(CMD_PUT, 0, CR_CODE, 8'h55, 0));
		offer_item(pack_item(CMD_PUT, 0, 8'h42, 8'h07, 0));
		offer_item(pack_item(CMD_PUT, 0, NL_CODE, 8'hAA, 0));
		offer_item(pack_item(CMD_READ, 0, 0, 0, 0));
		offer_item(pack_item(CMD_READ, 0, 0, 0, 2));
		offer_item(pack_item(CMD_BEGIN, ROWS - 1, 0, 0, 0));
		offer_item(pack_item(CMD_PUT, 0, 8'h5A, 8'h70, 0));
		offer_item(pack_item(CMD_PUT, 0, NL_CODE, 0, 0));
		offer_item(pack_item(CMD_READ, 0, 0, 0, CELL_COUNT - 1));
		offer_item(pack_item(CMD_READ, 0, 0, 0, CELL_COUNT - 2 * COLUMNS));
		offer_item(pack_item(CMD_READ, 0, 0, 0, CELL_COUNT));
		offer_item(pack_item(CMD_READ, 0, 0, 0, 2047));
		offer_item(pack_item(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF, 2047));
		offer_item(pack_item(CMD_BEGIN, 30, 0, 0, 0));
		offer_item(pack_item(CMD_PUT, 0, 8'h43, 8'h0F, 0));

		// Random part: mostly well-formed strings, then reads, noise, rejects
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				line = ($urandom_range(2) == 0) ? $urandom_range(ROWS - 1, ROWS - 5)
					: $urandom_range(ROWS - 1);
				offer_item(pack_item(CMD_BEGIN, line, $urandom, $urandom, $urandom));
				// long runs of printable bytes reach the right edge and wrap
				wide = ($urandom_range(5) == 0);
				len  = wide ? $urandom_range(170, 81) : $urandom_range(30, 1);
				for (int k = 0; k < len; k++) begin
					if (wide) begin
						ch = $urandom_range(255, 14);
					end else begin
						roll = $urandom_range(11);
						ch   = (roll == 0) ? NL_CODE : (roll == 1) ? CR_CODE : $urandom;
					end
					offer_item(pack_item(CMD_PUT, $urandom, ch, $urandom, $urandom));
				end
			end else if (pick < 85) begin
				repeat ($urandom_range(6, 1)) begin
					addr = ($urandom_range(9) == 0) ? $urandom_range(2047, CELL_COUNT)
						: $urandom_range(CELL_COUNT - 1);
					offer_item(pack_item(CMD_READ, $urandom, $urandom, $urandom, addr));
				end
			end else if (pick < 93) begin
				offer_item(pack_item(2'($urandom), $urandom, $urandom, $urandom, $urandom));
			end else begin
				offer_item(pack_item(CMD_BEGIN, $urandom_range(255, ROWS), $urandom,
					$urandom, $urandom));
				repeat ($urandom_range(2, 1))
					offer_item(pack_item(CMD_PUT, $urandom, $urandom, $urandom, $urandom));
			end
		end
		item_valid <= 1'b0;

		// Drain outstanding results, then allow for stray late ones
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d begins (%0d rejected), %0d puts (%0d with no string), %0d reads, %0d unused commands.",
			sb.cmd_count[CMD_BEGIN], sb.bad_lines, sb.cmd_count[CMD_PUT], sb.orphan_puts,
			sb.cmd_count[CMD_READ], sb.cmd_count[CMD_UNUSED]);
		$display("Checked %0d results across %0d scrolls and %0d lazy wraps, %0d mismatches.",
			sb.checked, sb.scrolls, sb.wraps, sb.mismatches);
		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
tb/text_console_writer_test.sv
